// File: hdl/rfe_pkg.sv
package rfe_pkg;

    localparam int MAX_FRAME_BYTES = 4096;
    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int LEN_W = 13;
    localparam int START_W = 13;
    localparam int CMP_W = ((POS_W > START_W) ? POS_W : START_W) + 1;
    localparam int CAP_BYTES = 8;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW = $clog2(Q_DEPTH + 1);

    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ENABLE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_INDEX  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_VALUE  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_START   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_COUNT   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_TYPE   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_ORDER   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_SELECT   = 4'd7;

    localparam logic [3:0] VT_BYTES  = 4'd0;
    localparam logic [3:0] VT_TEXT   = 4'd1;
    localparam logic [3:0] VT_BOOL   = 4'd2;
    localparam logic [3:0] VT_U16    = 4'd3;
    localparam logic [3:0] VT_S16    = 4'd4;
    localparam logic [3:0] VT_U32    = 4'd5;
    localparam logic [3:0] VT_S32    = 4'd6;
    localparam logic [3:0] VT_U64    = 4'd7;
    localparam logic [3:0] VT_S64    = 4'd8;
    localparam logic [3:0] VT_FLOAT  = 4'd9;
    localparam logic [3:0] VT_DOUBLE = 4'd10;

    localparam logic [1:0] BO_ABCD = 2'd0;
    localparam logic [1:0] BO_DCBA = 2'd1;
    localparam logic [1:0] BO_CDAB = 2'd2;
    localparam logic [1:0] BO_BADC = 2'd3;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_COND   = 3'd1,
        ST_START  = 3'd2,
        ST_BITOFF = 3'd3,
        ST_SHORT  = 3'd4,
        ST_TYPE   = 3'd5
    } t_status;

    typedef struct packed {
        logic               check_enable;
        logic [11:0]        check_index;
        logic [7:0]         check_value;
        logic [12:0]        data_start;
        logic [12:0]        data_count;
        logic [3:0]         value_type;
        logic [1:0]         byte_order;
        logic signed [4:0]  bit_select;
    } t_cfg;

    typedef struct packed {
        logic                           raw_vld;
        logic [7:0]                     raw_byte;
        logic                           fin_vld;
        t_status                        status;
        logic [POS_W-1:0]               taken;
        logic [CAP_BYTES-1:0][7:0]      cap;
    } t_entry;

    // region bytes a type needs: 1 for bool, 0 for raw and text
    function automatic logic [3:0] type_bytes(input logic [3:0] vt);
        logic [3:0] n;
        case (vt)
            VT_BOOL:                     n = 4'd1;
            VT_U16, VT_S16:              n = 4'd2;
            VT_U32, VT_S32, VT_FLOAT:    n = 4'd4;
            VT_U64, VT_S64, VT_DOUBLE:   n = 4'd8;
            default:                     n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

// File: hdl/response_field_extractor.sv
// channel   direction  handshake                 payload
// cfg       in         i_cfg_valid/o_cfg_ready    i_cfg_index, i_cfg_data
// in        in         i_in_valid/o_in_ready      i_frame_byte, i_frame_end
// out       out        o_out_valid/i_out_ready    o_is_final, o_raw_byte, o_status,
//                                                 o_decoded_value, o_region_length
//
// one frame byte is taken per cycle while the two-entry queue has room
// a byte gives at most two results; the output register sends one a cycle
// while i_out_ready is high; a last in-region byte stays at the queue head for both
// first result reaches the output through the queue and then the output register
// synchronous active-low reset clears counters, queue and output valid
// config is always ready; either side may stall without losing data
module response_field_extractor (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rfe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rfe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [7:0]                     i_frame_byte,
    input  logic                           i_frame_end,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_is_final,
    output logic [7:0]                     o_raw_byte,
    output logic [2:0]                     o_status,
    output logic [63:0]                    o_decoded_value,
    output logic [12:0]                    o_region_length
);

    rfe_pkg::t_cfg   r_cfg;
    rfe_pkg::t_entry push_entry;
    rfe_pkg::t_entry head;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_valid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.check_enable <= 1'b0;
            r_cfg.check_index  <= '0;
            r_cfg.check_value  <= '0;
            r_cfg.data_start   <= '0;
            r_cfg.data_count   <= '0;
            r_cfg.value_type   <= rfe_pkg::VT_BYTES;
            r_cfg.byte_order   <= rfe_pkg::BO_ABCD;
            r_cfg.bit_select   <= -5'sd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                rfe_pkg::CFG_CHECK_ENABLE: r_cfg.check_enable <= i_cfg_data[0];
                rfe_pkg::CFG_CHECK_INDEX:  r_cfg.check_index  <= i_cfg_data[11:0];
                rfe_pkg::CFG_CHECK_VALUE:  r_cfg.check_value  <= i_cfg_data[7:0];
                rfe_pkg::CFG_DATA_START:   r_cfg.data_start   <= i_cfg_data[12:0];
                rfe_pkg::CFG_DATA_COUNT:   r_cfg.data_count   <= i_cfg_data[12:0];
                rfe_pkg::CFG_VALUE_TYPE:   r_cfg.value_type   <= i_cfg_data[3:0];
                rfe_pkg::CFG_BYTE_ORDER:   r_cfg.byte_order   <= i_cfg_data[1:0];
                rfe_pkg::CFG_BIT_SELECT:   r_cfg.bit_select   <= signed'(i_cfg_data[4:0]);
                default: ;
            endcase
        end
    end

    rfe_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_in_valid),
        .i_byte   (i_frame_byte),
        .i_end    (i_frame_end),
        .o_ready  (o_in_ready),
        .i_q_full (q_full),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    rfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head),
        .i_pop   (pop)
    );

    rfe_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_valid       (q_valid),
        .i_head          (head),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_is_final      (o_is_final),
        .o_raw_byte      (o_raw_byte),
        .o_status        (o_status),
        .o_decoded_value (o_decoded_value),
        .o_region_length (o_region_length)
    );

endmodule

// File: hdl/rfe_front.sv
module rfe_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rfe_pkg::t_cfg        i_cfg,
    input  logic                 i_valid,
    input  logic [7:0]           i_byte,
    input  logic                 i_end,
    output logic                 o_ready,
    input  logic                 i_q_full,
    output logic                 o_push,
    output rfe_pkg::t_entry      o_entry
);

    logic [rfe_pkg::POS_W-1:0] r_pos, n_pos;
    logic                      r_passed, n_passed;
    logic [rfe_pkg::POS_W-1:0] r_taken, n_taken;
    logic [rfe_pkg::CAP_BYTES-1:0][7:0] r_cap, n_cap;

    logic                      acc;
    logic                      in_frame;
    logic                      in_region;
    logic                      take;
    logic [rfe_pkg::CMP_W-1:0] pos_x;
    logic [rfe_pkg::CMP_W-1:0] start_x;
    logic [rfe_pkg::CMP_W-1:0] end_x;
    logic [3:0]                need;
    rfe_pkg::t_status          status;

    assign o_ready = !i_q_full;
    assign acc     = i_valid && o_ready;

    assign in_frame = r_pos < rfe_pkg::POS_W'(rfe_pkg::MAX_FRAME_BYTES);
    assign pos_x    = rfe_pkg::CMP_W'(r_pos);
    assign start_x  = rfe_pkg::CMP_W'(i_cfg.data_start);
    assign end_x    = start_x + rfe_pkg::CMP_W'(i_cfg.data_count);

    assign in_region = (pos_x >= start_x)
                       && ((i_cfg.data_count == '0) || (pos_x < end_x));
    assign take = in_frame && in_region;

    always_comb begin
        n_passed = r_passed;
        if (in_frame && (pos_x == rfe_pkg::CMP_W'(i_cfg.check_index))) begin
            n_passed = (i_byte == i_cfg.check_value);
        end
        n_cap = r_cap;
        if (take && (r_taken < rfe_pkg::POS_W'(rfe_pkg::CAP_BYTES))) begin
            n_cap[r_taken[2:0]] = i_byte;
        end
        n_taken = r_taken + rfe_pkg::POS_W'(take);
        n_pos   = r_pos + rfe_pkg::POS_W'(in_frame);
    end

    // end of frame status, in priority order
    always_comb begin
        need = rfe_pkg::type_bytes(i_cfg.value_type);
        if (i_cfg.check_enable && !n_passed) begin
            status = rfe_pkg::ST_COND;
        end else if (start_x > rfe_pkg::CMP_W'(n_pos)) begin
            status = rfe_pkg::ST_START;
        end else if (!i_cfg.bit_select[4] && i_cfg.bit_select[3]) begin
            status = rfe_pkg::ST_BITOFF;
        end else if (i_cfg.value_type > rfe_pkg::VT_DOUBLE) begin
            status = rfe_pkg::ST_TYPE;
        end else if (n_taken < rfe_pkg::POS_W'(need)) begin
            status = rfe_pkg::ST_SHORT;
        end else begin
            status = rfe_pkg::ST_OK;
        end
    end

    assign o_push           = acc && (take || i_end);
    assign o_entry.raw_vld  = take;
    assign o_entry.raw_byte = i_byte;
    assign o_entry.fin_vld  = i_end;
    assign o_entry.status   = status;
    assign o_entry.taken    = n_taken;
    assign o_entry.cap      = n_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_passed <= 1'b0;
            r_taken  <= '0;
        end else if (acc) begin
            if (i_end) begin
                r_pos    <= '0;
                r_passed <= 1'b0;
                r_taken  <= '0;
            end else begin
                r_pos    <= n_pos;
                r_passed <= n_passed;
                r_taken  <= n_taken;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_cap <= n_cap;
        end
    end

endmodule

// File: hdl/rfe_queue.sv
module rfe_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rfe_pkg::t_entry  i_entry,
    output logic             o_full,
    output logic             o_valid,
    output rfe_pkg::t_entry  o_head,
    input  logic             i_pop
);

    rfe_pkg::t_entry             r_mem [rfe_pkg::Q_DEPTH];
    logic [rfe_pkg::Q_AW-1:0]    r_wptr;
    logic [rfe_pkg::Q_AW-1:0]    r_rptr;
    logic [rfe_pkg::Q_CW-1:0]    r_count;

    localparam logic [rfe_pkg::Q_AW-1:0] LAST = rfe_pkg::Q_AW'(rfe_pkg::Q_DEPTH - 1);

    assign o_full  = r_count == rfe_pkg::Q_CW'(rfe_pkg::Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == LAST) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == LAST) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

endmodule

// File: hdl/rfe_back.sv
module rfe_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rfe_pkg::t_cfg        i_cfg,
    input  logic                 i_q_valid,
    input  rfe_pkg::t_entry      i_head,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_is_final,
    output logic [7:0]           o_raw_byte,
    output logic [2:0]           o_status,
    output logic [63:0]          o_decoded_value,
    output logic [12:0]          o_region_length
);

    logic        r_out_valid;
    logic        r_raw_done;
    logic        r_is_final;
    logic [7:0]  r_raw_byte;
    logic [2:0]  r_status;
    logic [63:0] r_value;
    logic [12:0] r_length;

    logic        load;
    logic        emit_raw;
    logic [3:0]  need;
    logic [63:0] assembled;
    logic [63:0] value;

    function automatic logic [63:0] assemble(
        input logic [rfe_pkg::CAP_BYTES-1:0][7:0] cap,
        input logic [3:0] n,
        input logic [1:0] order
    );
        logic [63:0] v;
        logic [3:0]  kk;
        logic [3:0]  src;
        logic [3:0]  pos;
        v = '0;
        for (int k = 0; k < rfe_pkg::CAP_BYTES; k++) begin
            kk = 4'(k);
            case (order)
                rfe_pkg::BO_ABCD: src = kk;
                rfe_pkg::BO_DCBA: src = n - 4'd1 - kk;
                rfe_pkg::BO_CDAB: src = (n == 4'd2) ? kk
                                      : (((n >> 1) - 4'd1 - (kk >> 1)) << 1) | (kk & 4'd1);
                rfe_pkg::BO_BADC: src = (n == 4'd2) ? (n - 4'd1 - kk) : (kk ^ 4'd1);
                default:          src = kk;
            endcase
            // first byte of the order lands in the top byte of the value
            pos = n - 4'd1 - kk;
            if (kk < n) begin
                v[pos[2:0]*8 +: 8] = cap[src[2:0]];
            end
        end
        return v;
    endfunction

    assign need      = rfe_pkg::type_bytes(i_cfg.value_type);
    assign assembled = assemble(i_head.cap, need, i_cfg.byte_order);

    always_comb begin
        case (i_cfg.value_type)
            rfe_pkg::VT_BOOL: begin
                if (!i_cfg.bit_select[4]) begin
                    value = {63'd0, i_head.cap[0][i_cfg.bit_select[2:0]]};
                end else begin
                    value = {63'd0, |i_head.cap[0]};
                end
            end
            rfe_pkg::VT_S16:  value = {{48{assembled[15]}}, assembled[15:0]};
            rfe_pkg::VT_S32:  value = {{32{assembled[31]}}, assembled[31:0]};
            rfe_pkg::VT_U16, rfe_pkg::VT_U32, rfe_pkg::VT_U64, rfe_pkg::VT_S64,
            rfe_pkg::VT_FLOAT, rfe_pkg::VT_DOUBLE: value = assembled;
            default:          value = '0;
        endcase
        if (i_head.status != rfe_pkg::ST_OK) begin
            value = '0;
        end
    end

    assign load     = !r_out_valid || i_out_ready;
    assign emit_raw = i_head.raw_vld && !r_raw_done;
    assign o_pop    = load && i_q_valid && (!emit_raw || !i_head.fin_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_raw_done  <= 1'b0;
        end else if (load) begin
            r_out_valid <= i_q_valid;
            if (i_q_valid) begin
                // a byte that also ends the frame sends its raw transfer first
                r_raw_done <= emit_raw && i_head.fin_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_q_valid) begin
            if (emit_raw) begin
                r_is_final <= 1'b0;
                r_raw_byte <= i_head.raw_byte;
                r_status   <= rfe_pkg::ST_OK;
                r_value    <= '0;
                r_length   <= '0;
            end else begin
                r_is_final <= 1'b1;
                r_raw_byte <= '0;
                r_status   <= i_head.status;
                r_value    <= value;
                r_length   <= rfe_pkg::LEN_W'(i_head.taken);
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_is_final      = r_is_final;
    assign o_raw_byte      = r_raw_byte;
    assign o_status        = r_status;
    assign o_decoded_value = r_value;
    assign o_region_length = r_length;

endmodule
